@@ rtl/sha1_pkg.sv @@
package sha1_pkg;

   typedef enum logic {
      OP_FEED   = 1'b0,
      OP_FINISH = 1'b1
   } op_type;

   typedef struct packed {
      logic [0:0] op;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // Queue entry between intake and the hash engine.
   typedef struct packed {
      logic       finish;
      logic [7:0] data_byte;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_PAD,
      ST_LEN,
      ST_OUT
   } state_type;

   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hefcdab89;
   localparam logic [31:0] H2 = 32'h98badcfe;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hc3d2e1f0;
   localparam logic [31:0] K0 = 32'h5a827999;
   localparam logic [31:0] K1 = 32'h6ed9eba1;
   localparam logic [31:0] K2 = 32'h8f1bbcdc;
   localparam logic [31:0] K3 = 32'hca62c1d6;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [5:0]  LEN_OFFSET = 6'd56;

endpackage

@@ rtl/sha1_front.sv @@
module sha1_front
   import sha1_pkg::*;
#(
   parameter int Depth = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    cmd_valid,
   input  logic    cmd_ready,
   output cmd_type cmd_data
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   cmd_type         fifo_ff [Depth];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]     count_ff, count_in;
   logic            push, pop;

   assign req_ready = (count_ff != (AW+1)'(Depth));
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = fifo_ff[rd_ptr_ff];
   assign push = req_valid && req_ready;
   assign pop  = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= '{finish: (req_payload.op == OP_FINISH),
                                 data_byte: req_payload.data_byte};
      end
   end
endmodule

@@ rtl/sha1_back.sv @@
module sha1_back
   import sha1_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);
   state_type     state_ff, state_in;
   logic [31:0]   w_ff [16];
   logic [31:0]   h_ff [5];
   logic [31:0]   a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [6:0]    rnd_ff, rnd_in;
   logic [5:0]    cnt_ff;
   logic [63:0]   len_ff, flen_ff;
   logic [2:0]    lenb_ff, oidx_ff;
   logic          fin_ff;
   // Set once all eight length bytes have been absorbed.
   logic          len_seen_ff;
   logic          absorb;
   logic [7:0]    abyte;
   logic [31:0]   f, k, t, wn, w0;

   // Byte absorbed this cycle, from the queue or from the pad/length sequencer.
   always_comb begin
      absorb = 1'b0;
      abyte  = 8'h00;
      cmd_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               absorb = 1'b1;
               abyte  = cmd_data.finish ? PAD_BYTE : cmd_data.data_byte;
            end
         end
         ST_PAD: begin
            absorb = 1'b1;
         end
         ST_LEN: begin
            absorb = 1'b1;
            abyte  = flen_ff[8*(7-lenb_ff) +: 8];
         end
         default: ;
      endcase
   end

   // Round logic, message schedule kept as a 16-word sliding window.
   always_comb begin
      w0 = w_ff[0];
      if (rnd_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff); k = K0;
      end else if (rnd_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff; k = K1;
      end else if (rnd_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff); k = K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff; k = K3;
      end
      t  = {a_ff[26:0], a_ff[31:27]} + f + e_ff + w0 + k;
      wn = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      wn = {wn[30:0], wn[31]};
   end

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      unique case (state_ff)
         ST_IDLE: if (absorb && cnt_ff == 6'd63) begin
            state_in = ST_ROUND; rnd_in = '0;
         end else if (absorb && cmd_data.finish) begin
            state_in = (cnt_ff + 6'd1 == LEN_OFFSET) ? ST_LEN : ST_PAD;
         end
         // After a compression during finish: continue padding or emit.
         ST_ROUND: begin
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'd80) begin
               if (!fin_ff) state_in = ST_IDLE;
               else if (len_seen_ff) state_in = ST_OUT;
               else state_in = ST_PAD;
            end
         end
         ST_PAD: if (cnt_ff == 6'd63) begin
            state_in = ST_ROUND; rnd_in = '0;
         end else if (cnt_ff + 6'd1 == LEN_OFFSET) begin
            state_in = ST_LEN;
         end
         ST_LEN: if (cnt_ff == 6'd63) begin
            state_in = ST_ROUND; rnd_in = '0;
         end
         ST_OUT: if (rsp_ready && oidx_ff == 3'd4) begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_payload = '{digest_word: h_ff[oidx_ff], word_index: oidx_ff,
                          last_word: (oidx_ff == 3'd4)};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= '0;
         cnt_ff   <= '0;
         len_ff   <= '0;
         fin_ff   <= 1'b0;
         lenb_ff  <= '0;
         oidx_ff  <= '0;
         len_seen_ff <= 1'b0;
         h_ff <= '{H0, H1, H2, H3, H4};
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         if (absorb) begin
            cnt_ff <= cnt_ff + 6'd1;
         end
         if (state_ff == ST_IDLE && absorb) begin
            if (cmd_data.finish) begin
               fin_ff  <= 1'b1;
               flen_ff <= len_ff;
               lenb_ff <= '0;
            end else begin
               len_ff <= len_ff + 64'd8;
            end
         end
         if (state_ff == ST_LEN) begin
            lenb_ff <= lenb_ff + 3'd1;
            if (lenb_ff == 3'd7) len_seen_ff <= 1'b1;
         end
         if (state_ff != ST_ROUND && state_in == ST_ROUND) begin
            a_ff <= h_ff[0]; b_ff <= h_ff[1]; c_ff <= h_ff[2];
            d_ff <= h_ff[3]; e_ff <= h_ff[4];
         end else if (state_ff == ST_ROUND && rnd_ff < 7'd80) begin
            a_ff <= t; b_ff <= a_ff; c_ff <= {b_ff[1:0], b_ff[31:2]};
            d_ff <= c_ff; e_ff <= d_ff;
         end
         if (state_ff == ST_ROUND && rnd_ff == 7'd80) begin
            h_ff[0] <= h_ff[0] + a_ff; h_ff[1] <= h_ff[1] + b_ff;
            h_ff[2] <= h_ff[2] + c_ff; h_ff[3] <= h_ff[3] + d_ff;
            h_ff[4] <= h_ff[4] + e_ff;
         end
         if (state_ff == ST_OUT && rsp_ready) begin
            if (oidx_ff == 3'd4) begin
               oidx_ff <= '0;
               fin_ff  <= 1'b0;
               len_seen_ff <= 1'b0;
               len_ff  <= '0;
               cnt_ff  <= '0;
               h_ff <= '{H0, H1, H2, H3, H4};
            end else begin
               oidx_ff <= oidx_ff + 3'd1;
            end
         end
      end
   end

   // Block window: bytes shift into the word picked by the byte count;
   // during rounds the window slides and takes the next schedule word.
   always_ff @(posedge clock) begin
      if (absorb) begin
         w_ff[cnt_ff[5:2]] <= {w_ff[cnt_ff[5:2]][23:0], abyte};
      end else if (state_ff == ST_ROUND && rnd_ff < 7'd80) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= wn;
      end
   end
endmodule

@@ rtl/sha1_byte_stream_hasher.sv @@
// SHA-1 hasher fed one byte per request.
// The request channel (req_valid/req_ready/req_payload) carries either a
// message byte (op feed) or a finish marker (op finish). Requests land in a
// four-entry queue, so the sender keeps going while the hash engine works.
// The engine packs bytes big-endian into a 64-byte block window and runs
// the 80 rounds one per cycle when the block fills, taking no new bytes
// while the rounds run, then adds the result into the hash state.
// On finish the engine appends 0x80, zeros up to byte 56 and the 64-bit
// bit length, one byte per cycle, compresses once or twice, then offers
// the five digest words on rsp_valid/rsp_ready with word_index and
// last_word. rsp_valid rises once the last compression is done; bytes
// queued ahead of the finish or a compression in progress delay it.
// While rsp_ready is low the current word holds and the engine waits; the
// queue keeps taking requests until it is full.
// After the fifth word is taken the state returns to the SHA-1 initial
// values. Synchronous reset clears the queue and the hash state at once.
module sha1_byte_stream_hasher
   import sha1_pkg::*;
#(
   parameter int QueueDepth = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);
   logic    cmd_valid, cmd_ready;
   cmd_type cmd_data;

   sha1_front #(.Depth(QueueDepth)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_payload,
      .cmd_valid, .cmd_ready, .cmd_data
   );

   sha1_back u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_data,
      .rsp_valid, .rsp_ready, .rsp_payload
   );
endmodule
